// ----- rtl/gbn_pkg.sv -----
// Package for the Go-Back-N sender window.
// Holds field widths, request codes, register indexes, reset values and shared structs.
// No dependencies.
`default_nettype none

package gbn_pkg;

	localparam int SEQ_COUNT_DEF = 20;
	localparam int SEQ_W         = 5;
	localparam int CNT_W         = 16;
	localparam int WIN_W         = 5;
	localparam int TMO_W         = 8;
	localparam int KIND_W        = 2;
	localparam int ACK_W         = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_START    = 2'd0,
		KIND_POLL     = 2'd1,
		KIND_POLL_ACK = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW  = 2'd0,
		REG_TOTAL   = 2'd1,
		REG_TIMEOUT = 2'd2
	} reg_idx_t;

	localparam logic [WIN_W-1:0] WINDOW_RST  = 5'd10;
	localparam logic [CNT_W-1:0] TOTAL_RST   = 16'd4;
	localparam logic [TMO_W-1:0] TIMEOUT_RST = 8'd20;

	typedef struct packed {
		logic [WIN_W-1:0] window;
		logic [CNT_W-1:0] total;
		logic [TMO_W-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ACK_W-1:0]  ack_seq;
	} req_t;

	typedef struct packed {
		logic             send_valid;
		logic [SEQ_W-1:0] send_seq;
		logic [CNT_W-1:0] packet_index;
		logic             ack_accepted;
		logic             timeout_fired;
		logic [CNT_W-1:0] acked_total;
		logic             done_res;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/gbn_in_if.sv -----
// Request channel of the sender window: kind and acknowledgement byte.
// Depends on gbn_pkg for field widths.
`default_nettype none

interface gbn_in_if;
	logic                         valid;
	logic                         ready;
	logic [gbn_pkg::KIND_W-1:0]   kind;
	logic [gbn_pkg::ACK_W-1:0]    ack_seq;

	modport source (output valid, output kind, output ack_seq, input ready);
	modport sink (input valid, input kind, input ack_seq, output ready);
endinterface

`default_nettype wire

// ----- rtl/gbn_out_if.sv -----
// Result channel of the sender window: one result per request.
// Depends on gbn_pkg for field widths.
`default_nettype none

interface gbn_out_if;
	logic                         valid;
	logic                         ready;
	logic                         send_valid;
	logic [gbn_pkg::SEQ_W-1:0]    send_seq;
	logic [gbn_pkg::CNT_W-1:0]    packet_index;
	logic                         ack_accepted;
	logic                         timeout_fired;
	logic [gbn_pkg::CNT_W-1:0]    acked_total;
	logic                         done_res;

	modport source (output valid, output send_valid, output send_seq, output packet_index,
		output ack_accepted, output timeout_fired, output acked_total, output done_res,
		input ready);
	modport sink (input valid, input send_valid, input send_seq, input packet_index,
		input ack_accepted, input timeout_fired, input acked_total, input done_res,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/gbn_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on gbn_pkg for field widths.
`default_nettype none

interface gbn_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [gbn_pkg::CFG_IDX_W-1:0]    reg_index;
	logic [gbn_pkg::CFG_DATA_W-1:0]   wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/gbn_cfg_regs.sv -----
// Configuration register file of the sender window.
// Depends on gbn_pkg and gbn_cfg_if.
`default_nettype none

module gbn_cfg_regs (
	input  wire logic    clk,
	input  wire logic    arst_n,
	gbn_cfg_if.sink      cfg,
	output gbn_pkg::cfg_t regs
);
	import gbn_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.window  <= WINDOW_RST;
			regs_q.total   <= TOTAL_RST;
			regs_q.timeout <= TIMEOUT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.reg_index)
				REG_WINDOW:  regs_q.window  <= cfg.wdata[WIN_W-1:0];
				REG_TOTAL:   regs_q.total   <= cfg.wdata[CNT_W-1:0];
				REG_TIMEOUT: regs_q.timeout <= cfg.wdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/gbn_core.sv -----
// Session state and combinational step logic of the sender window.
// Depends on gbn_pkg.
`default_nettype none

module gbn_core #(
	parameter int SEQ_COUNT = gbn_pkg::SEQ_COUNT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  gbn_pkg::req_t  req,
	input  gbn_pkg::cfg_t  cfg,
	output gbn_pkg::res_t  res
);
	import gbn_pkg::*;

	localparam logic [SEQ_W:0]   SEQ_N    = (SEQ_W+1)'(SEQ_COUNT);
	localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_COUNT - 1);
	localparam logic [ACK_W-1:0] ACK_MAX  = ACK_W'(SEQ_COUNT);

	logic [SEQ_W-1:0] next_seq_q, base_seq_q;
	logic [CNT_W-1:0] sent_count_q, acked_count_q;
	logic [TMO_W-1:0] silent_polls_q;
	logic             active_q;

	logic [SEQ_W-1:0] n_next, n_base;
	logic [CNT_W-1:0] n_sent, n_acked;
	logic [TMO_W-1:0] n_silent;
	logic             n_active;

	logic [WIN_W-1:0] win_eff;
	logic [CNT_W-1:0] outstanding;
	logic [CNT_W:0]   out_after;
	logic             poll, issue, ack_ok, cover_ok;
	logic [SEQ_W-1:0] seq_inc, slot, base_new;
	logic [SEQ_W:0]   span, covered;
	logic [CNT_W-1:0] acked_new;

	always_comb begin
		if (cfg.window == '0) begin
			win_eff = WIN_W'(1);
		end else if (cfg.window > SEQ_LAST) begin
			win_eff = SEQ_LAST;
		end else begin
			win_eff = cfg.window;
		end

		poll        = (req.kind == KIND_POLL) || (req.kind == KIND_POLL_ACK);
		outstanding = sent_count_q - acked_count_q;
		issue       = poll && active_q && (outstanding < CNT_W'(win_eff))
			&& (sent_count_q < cfg.total);
		seq_inc     = (next_seq_q == SEQ_LAST) ? '0 : next_seq_q + 1'b1;
		out_after   = {1'b0, outstanding} + (CNT_W+1)'(issue);

		ack_ok = (req.ack_seq != '0) && (req.ack_seq <= ACK_MAX);
		slot   = SEQ_W'(req.ack_seq - 1'b1);
		if (slot >= base_seq_q) begin
			span = {1'b0, slot} - {1'b0, base_seq_q};
		end else begin
			span = {1'b0, slot} + SEQ_N - {1'b0, base_seq_q};
		end
		covered   = span + 1'b1;
		cover_ok  = ack_ok && ((CNT_W+1)'(covered) <= out_after);
		acked_new = acked_count_q + CNT_W'(covered);
		base_new  = (slot == SEQ_LAST) ? '0 : slot + 1'b1;

		n_next   = next_seq_q;
		n_base   = base_seq_q;
		n_sent   = sent_count_q;
		n_acked  = acked_count_q;
		n_silent = silent_polls_q;
		n_active = active_q;
		res      = '0;

		if (issue) begin
			res.send_valid   = 1'b1;
			res.send_seq     = next_seq_q + 1'b1;
			res.packet_index = sent_count_q;
			n_next           = seq_inc;
			n_sent           = sent_count_q + 1'b1;
		end

		case (req.kind)
			KIND_START: begin
				n_next   = '0;
				n_base   = '0;
				n_sent   = '0;
				n_acked  = '0;
				n_silent = '0;
				n_active = (cfg.total != '0);
				res.done_res = (cfg.total == '0);
			end
			KIND_POLL: begin
				if (active_q) begin
					if (silent_polls_q >= cfg.timeout) begin
						n_next            = base_seq_q;
						n_sent            = acked_count_q;
						n_silent          = '0;
						res.timeout_fired = 1'b1;
					end else begin
						n_silent = silent_polls_q + 1'b1;
					end
				end
			end
			KIND_POLL_ACK: begin
				if (active_q) begin
					n_silent = '0;
					if (cover_ok) begin
						n_acked          = acked_new;
						n_base           = base_new;
						res.ack_accepted = 1'b1;
						if (acked_new == cfg.total) begin
							n_active     = 1'b0;
							res.done_res = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		res.acked_total = n_acked;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q     <= '0;
			base_seq_q     <= '0;
			sent_count_q   <= '0;
			acked_count_q  <= '0;
			silent_polls_q <= '0;
			active_q       <= 1'b0;
		end else if (step) begin
			next_seq_q     <= n_next;
			base_seq_q     <= n_base;
			sent_count_q   <= n_sent;
			acked_count_q  <= n_acked;
			silent_polls_q <= n_silent;
			active_q       <= n_active;
		end
	end

	// The pointers stay inside the sequence space.
	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_seq_q < SEQ_N) && (base_seq_q < SEQ_N))
		else $error("sequence pointer out of range");

	// Cumulative acks never cover more packets than were issued.
	a_acked_le_sent: assert property (@(posedge clk) disable iff (!arst_n)
		acked_count_q <= sent_count_q)
		else $error("acked count exceeds sent count");

	// A finished session is idle afterwards.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |=> !active_q)
		else $error("session still active after done");

	// A rewind restarts the silence count and returns to the window base.
	a_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.timeout_fired |=> (silent_polls_q == '0) && (sent_count_q == acked_count_q))
		else $error("rewind did not restore the window");

endmodule

`default_nettype wire

// ----- rtl/gbn_sender_window.sv -----
// Go-Back-N sender window: one result per request, a new request every cycle while results are
// taken; a request is held in req_s1, the session steps, and its result is registered in res_s2.
// Configuration writes are always ready and take effect on the next request.
// Depends on gbn_pkg, gbn_in_if, gbn_out_if, gbn_cfg_if, gbn_cfg_regs and gbn_core.
`default_nettype none

module gbn_sender_window #(
	parameter int SEQ_COUNT = gbn_pkg::SEQ_COUNT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	gbn_in_if.sink    item,
	gbn_out_if.source result,
	gbn_cfg_if.sink   cfg
);
	import gbn_pkg::*;

	cfg_t regs;
	req_t req_s1;
	res_t core_res, res_s2;
	logic valid_s1, valid_s2;
	logic adv, step;

	assign adv        = !valid_s2 || result.ready;
	assign step       = valid_s1 && adv;
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			req_s1.kind    <= item.kind;
			req_s1.ack_seq <= item.ack_seq;
		end
		if (step) begin
			res_s2 <= core_res;
		end
	end

	gbn_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	gbn_core #(
		.SEQ_COUNT (SEQ_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (req_s1),
		.cfg    (regs),
		.res    (core_res)
	);

	assign result.valid         = valid_s2;
	assign result.send_valid    = res_s2.send_valid;
	assign result.send_seq      = res_s2.send_seq;
	assign result.packet_index  = res_s2.packet_index;
	assign result.ack_accepted  = res_s2.ack_accepted;
	assign result.timeout_fired = res_s2.timeout_fired;
	assign result.acked_total   = res_s2.acked_total;
	assign result.done_res      = res_s2.done_res;

endmodule

`default_nettype wire
